@@ rtl/tsni_pkg.sv @@
// tsni_pkg: types and constants for the TLS ClientHello server-name locator.
// Used by the interfaces, the parser, the result register and the top level.
package tsni_pkg;

    localparam int STATUS_BITS = 3;
    localparam int FIELD_BITS  = 16;
    localparam int SKIP_BITS   = 17;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_SKIP      = 4'd1,
        PH_TYPE      = 4'd2,
        PH_SID       = 4'd3,
        PH_CS_HI     = 4'd4,
        PH_CS_LO     = 4'd5,
        PH_ET_HI     = 4'd6,
        PH_ET_LO     = 4'd7,
        PH_EL_HI     = 4'd8,
        PH_EL_LO     = 4'd9,
        PH_NAME_TYPE = 4'd10,
        PH_HL_HI     = 4'd11,
        PH_HL_LO     = 4'd12,
        PH_HOST      = 4'd13
    } t_phase;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_HELLO = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_NO_SNI    = 3'd3,
        ST_BAD_TYPE  = 3'd4
    } t_status;

    typedef struct packed {
        logic                  emit;
        t_status               status;
        logic [FIELD_BITS-1:0] name_offset;
        logic [FIELD_BITS-1:0] name_length;
    } t_result;

    localparam logic [7:0]           CLIENT_HELLO     = 8'h01;
    localparam logic [7:0]           NAME_TYPE_HOST   = 8'h00;
    localparam logic [7:0]           EXT_SERVER_NAME  = 8'h00;
    localparam logic [SKIP_BITS-1:0] HEADER_BYTES     = 17'd5;
    localparam logic [SKIP_BITS-1:0] FIXED_PART_SKIP  = 17'd37;
    localparam logic [SKIP_BITS-1:0] COMP_EXTLEN_SKIP = 17'd4;
    localparam logic [SKIP_BITS-1:0] SNI_LISTLEN_SKIP = 17'd4;

endpackage

@@ rtl/tsni_if.sv @@
// tsni_if: valid/ready channels for record bytes and locator results.
// Depends on tsni_pkg for field widths.
interface tsni_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsni_result_if;
    logic                              valid;
    logic                              ready;
    logic [tsni_pkg::STATUS_BITS-1:0]  status;
    logic [tsni_pkg::FIELD_BITS-1:0]   name_offset;
    logic [tsni_pkg::FIELD_BITS-1:0]   name_length;

    modport source (output valid, output status, output name_offset,
                    output name_length, input ready);
    modport sink   (input valid, input status, input name_offset,
                    input name_length, output ready);
endinterface

@@ rtl/tls_client_hello_sni_locator_top.sv @@
// tls_client_hello_sni_locator_top: TLS ClientHello server-name locator.
// Depends on tsni_pkg, tsni_if, tsni_parser and tsni_out_reg.
//
// Usage:
//   i_byte carries one record byte per item (data_byte, last_byte marks the
//   final byte). o_result carries one item per record: status, name_offset
//   and name_length (offset counted from the first header byte).
//   A result appears the cycle after the byte that decides it: the handshake
//   type byte, the name type byte, the low byte of a zero hostname length,
//   the last hostname byte, or the last byte of the record. Bytes after a
//   decided result are consumed and ignored. Throughput is one byte per cycle;
//   the parse state advances in a single registered step per byte, and the
//   result register frees itself in the same cycle it is taken.
//   When o_result stalls with a result held, i_byte.ready drops until the
//   result is taken; bytes that decide nothing still need that slot free.
//   Reset (synchronous, active low) returns the parser to the record header
//   and empties the result register. The last byte of a record also resets
//   the parser for the next record.
module tls_client_hello_sni_locator_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsni_byte_if.sink     i_byte,
    tsni_result_if.source o_result
);
    import tsni_pkg::*;

    t_result res;
    logic    can_load;
    logic    accept;

    assign i_byte.ready = can_load;
    assign accept       = i_byte.valid && can_load;

    tsni_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_res       (res)
    );

    tsni_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res.emit),
        .i_res      (res),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule

@@ rtl/tsni_parser.sv @@
// tsni_parser: per-byte parse state machine and result decision.
// Depends on tsni_pkg; advances only on accepted bytes.
module tsni_parser #(
    parameter int POSITION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output tsni_pkg::t_result o_res
);
    import tsni_pkg::*;

    localparam int EXT_BITS = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;

    t_phase                   r_phase, n_phase;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [SKIP_BITS-1:0]     r_skip, n_skip;
    logic [7:0]               r_lhb, n_lhb;
    logic                     r_given, n_given;
    logic [FIELD_BITS-1:0]    r_held, n_held;

    t_phase                   step_phase;
    logic [SKIP_BITS-1:0]     step_skip;
    logic [7:0]               step_lhb;
    logic [FIELD_BITS-1:0]    step_held;
    logic                     step_given;
    logic [SKIP_BITS-1:0]     dec_skip;
    logic [FIELD_BITS-1:0]    word;
    logic [EXT_BITS-1:0]      pos_ext;
    logic [FIELD_BITS-1:0]    pos16;
    t_result                  res;

    assign dec_skip = (r_skip != '0) ? r_skip - 17'd1 : r_skip;
    assign word     = {r_lhb, i_data_byte};
    assign pos_ext  = EXT_BITS'(r_pos);
    assign pos16    = pos_ext[FIELD_BITS-1:0];

    // next state
    always_comb begin
        step_phase = r_phase;
        step_skip  = r_skip;
        step_lhb   = r_lhb;
        step_held  = r_held;
        step_given = r_given;
        if (!r_given) begin
            unique case (r_phase)
                PH_HEADER: begin
                    step_skip = dec_skip;
                    if (dec_skip == '0) step_phase = PH_TYPE;
                end
                PH_SKIP: begin
                    step_skip = dec_skip;
                    if (dec_skip == '0) step_phase = t_phase'(r_lhb[3:0]);
                end
                PH_TYPE: begin
                    if (i_data_byte != CLIENT_HELLO) begin
                        step_given = 1'b1;
                    end else begin
                        step_skip  = FIXED_PART_SKIP;
                        step_lhb   = 8'(PH_SID);
                        step_phase = PH_SKIP;
                    end
                end
                PH_SID: begin
                    if (i_data_byte == 8'd0) begin
                        step_phase = PH_CS_HI;
                    end else begin
                        step_skip  = SKIP_BITS'(i_data_byte);
                        step_lhb   = 8'(PH_CS_HI);
                        step_phase = PH_SKIP;
                    end
                end
                PH_CS_HI, PH_ET_HI, PH_EL_HI, PH_HL_HI: begin
                    step_lhb   = i_data_byte;
                    step_phase = t_phase'(r_phase + 4'd1);
                end
                PH_CS_LO: begin
                    step_skip  = SKIP_BITS'(word) + COMP_EXTLEN_SKIP;
                    step_lhb   = 8'(PH_ET_HI);
                    step_phase = PH_SKIP;
                end
                PH_ET_LO: begin
                    if (r_lhb == EXT_SERVER_NAME && i_data_byte == EXT_SERVER_NAME) begin
                        step_skip  = SNI_LISTLEN_SKIP;
                        step_lhb   = 8'(PH_NAME_TYPE);
                        step_phase = PH_SKIP;
                    end else begin
                        step_phase = PH_EL_HI;
                    end
                end
                PH_EL_LO: begin
                    if (word == '0) begin
                        step_phase = PH_ET_HI;
                    end else begin
                        step_skip  = SKIP_BITS'(word);
                        step_lhb   = 8'(PH_ET_HI);
                        step_phase = PH_SKIP;
                    end
                end
                PH_NAME_TYPE: begin
                    if (i_data_byte != NAME_TYPE_HOST) step_given = 1'b1;
                    else step_phase = PH_HL_HI;
                end
                PH_HL_LO: begin
                    if (word == '0) begin
                        step_given = 1'b1;
                    end else begin
                        step_held  = word;
                        step_skip  = SKIP_BITS'(word);
                        step_phase = PH_HOST;
                    end
                end
                PH_HOST: begin
                    step_skip = dec_skip;
                    if (dec_skip == '0) step_given = 1'b1;
                end
                default: step_phase = PH_HEADER;
            endcase
        end

        if (i_last_byte) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
            n_skip  = HEADER_BYTES;
            n_lhb   = '0;
            n_given = 1'b0;
            n_held  = '0;
        end else begin
            n_phase = step_phase;
            n_pos   = (r_pos != '1) ? r_pos + POSITION_BITS'(1) : r_pos;
            n_skip  = step_skip;
            n_lhb   = step_lhb;
            n_given = step_given;
            n_held  = step_held;
        end
    end

    // result decision
    always_comb begin
        res = '0;
        if (!r_given) begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (i_data_byte != CLIENT_HELLO) begin
                        res.emit   = 1'b1;
                        res.status = ST_NOT_HELLO;
                    end
                end
                PH_NAME_TYPE: begin
                    if (i_data_byte != NAME_TYPE_HOST) begin
                        res.emit   = 1'b1;
                        res.status = ST_BAD_TYPE;
                    end
                end
                PH_HL_LO: begin
                    if (word == '0) begin
                        res.emit        = 1'b1;
                        res.status      = ST_FOUND;
                        res.name_offset = pos16 + 16'd1;
                    end
                end
                PH_HOST: begin
                    if (dec_skip == '0) begin
                        res.emit        = 1'b1;
                        res.status      = ST_FOUND;
                        res.name_offset = pos16 + 16'd1 - r_held;
                        res.name_length = r_held;
                    end
                end
                default: res = '0;
            endcase
        end
        if (i_last_byte && !step_given) begin
            res.emit   = 1'b1;
            res.status = (step_phase == PH_ET_HI) ? ST_NO_SNI : ST_TRUNC;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_skip  <= HEADER_BYTES;
            r_lhb   <= '0;
            r_given <= 1'b0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_lhb   <= n_lhb;
            r_given <= n_given;
            r_held  <= n_held;
        end
    end

endmodule

@@ rtl/tsni_out_reg.sv @@
// tsni_out_reg: result register that drives the result channel.
// Depends on tsni_pkg and tsni_if; frees itself when the result is taken.
module tsni_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tsni_pkg::t_result i_res,
    output logic              o_can_load,
    tsni_result_if.source     o_result
);
    import tsni_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.status      = r_res.status;
    assign o_result.name_offset = r_res.name_offset;
    assign o_result.name_length = r_res.name_length;

endmodule

@@ rtl/tsni_checker.sv @@
// tsni_checker: port-level checks for the server-name locator.
// Depends on tsni_pkg; bound to tls_client_hello_sni_locator_top.
module tsni_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [tsni_pkg::STATUS_BITS-1:0] i_status,
    input logic [tsni_pkg::FIELD_BITS-1:0]  i_name_offset,
    input logic [tsni_pkg::FIELD_BITS-1:0]  i_name_length
);
    import tsni_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_name_offset) && $stable(i_name_length))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_BAD_TYPE)
        else $error("status code out of range");

    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_FOUND |-> i_name_offset == '0 && i_name_length == '0)
        else $error("offset or length set without a found name");

    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result appeared without an accepted byte");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind tls_client_hello_sni_locator_top tsni_checker u_tsni_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_byte.valid),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_name_offset (o_result.name_offset),
    .i_name_length (o_result.name_length)
);

@@ tb/tls_client_hello_sni_locator_top_tb.sv @@
// Testbench for tls_client_hello_sni_locator_top: streams TLS records byte by byte and checks
// each locator result against a cycle-free model of the ClientHello walk.
// Depends on tsni_pkg, the tsni_if channels and the RTL top level.
`timescale 1ns / 100ps

module tls_client_hello_sni_locator_top_tb;
    import tsni_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] data;
        logic       lastb;
    } t_rec_byte;

    typedef struct {
        t_status         status;
        logic [15:0]     name_offset;
        logic [15:0]     name_length;
    } t_sni_result;

    logic i_clk;
    logic i_rst_n;

    tsni_byte_if   byte_ch ();
    tsni_result_if result_ch ();

    tls_client_hello_sni_locator_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    t_rec_byte   bytes_to_send[$];
    t_sni_result results_due[$];
    logic [7:0]  rec_bytes[$];

    t_phase      ph;
    logic [15:0] bpos;
    logic [16:0] skip_left;
    logic [7:0]  hi_byte;
    bit          decided;
    logic [15:0] held_len;

    int  err_count;
    int  bytes_shipped;
    int  recs_shipped;
    int  bytes_accepted;
    int  status_seen[5];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    bit  byte_taken;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic walk_reset();
        ph        = PH_HEADER;
        bpos      = '0;
        skip_left = HEADER_BYTES;
        hi_byte   = '0;
        decided   = 1'b0;
        held_len  = '0;
    endtask

    task automatic begin_skip(input logic [16:0] n, input t_phase nxt);
        if (n == '0) begin
            ph = nxt;
        end else begin
            skip_left = n;
            hi_byte   = {4'd0, nxt};
            ph        = PH_SKIP;
        end
    endtask

    task automatic post_result(input t_status s, input logic [15:0] off,
                               input logic [15:0] len);
        t_sni_result r;
        r.status      = s;
        r.name_offset = off;
        r.name_length = len;
        results_due.push_back(r);
        status_seen[s]++;
        decided = 1'b1;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic lastb);
        if (!decided) begin
            case (ph)
                PH_HEADER: begin
                    if (skip_left != '0) skip_left--;
                    if (skip_left == '0) ph = PH_TYPE;
                end
                PH_SKIP: begin
                    if (skip_left != '0) skip_left--;
                    if (skip_left == '0) ph = t_phase'(hi_byte[3:0]);
                end
                PH_TYPE: begin
                    if (b != CLIENT_HELLO) post_result(ST_NOT_HELLO, '0, '0);
                    else begin_skip(FIXED_PART_SKIP, PH_SID);
                end
                PH_SID: begin
                    begin_skip({9'd0, b}, PH_CS_HI);
                end
                PH_CS_HI, PH_ET_HI, PH_EL_HI, PH_HL_HI: begin
                    hi_byte = b;
                    ph      = t_phase'(ph + 4'd1);
                end
                PH_CS_LO: begin
                    begin_skip({1'b0, hi_byte, b} + COMP_EXTLEN_SKIP, PH_ET_HI);
                end
                PH_ET_LO: begin
                    if (hi_byte == EXT_SERVER_NAME && b == EXT_SERVER_NAME)
                        begin_skip(SNI_LISTLEN_SKIP, PH_NAME_TYPE);
                    else
                        ph = PH_EL_HI;
                end
                PH_EL_LO: begin
                    begin_skip({1'b0, hi_byte, b}, PH_ET_HI);
                end
                PH_NAME_TYPE: begin
                    if (b != NAME_TYPE_HOST) post_result(ST_BAD_TYPE, '0, '0);
                    else ph = PH_HL_HI;
                end
                PH_HL_LO: begin
                    if ({hi_byte, b} == 16'd0) begin
                        post_result(ST_FOUND, bpos + 16'd1, '0);
                    end else begin
                        held_len  = {hi_byte, b};
                        skip_left = {1'b0, hi_byte, b};
                        ph        = PH_HOST;
                    end
                end
                PH_HOST: begin
                    if (skip_left != '0) skip_left--;
                    if (skip_left == '0)
                        post_result(ST_FOUND, bpos + 16'd1 - held_len, held_len);
                end
                default: begin
                    ph = PH_HEADER;
                end
            endcase
        end
        if (lastb) begin
            if (!decided) post_result((ph == PH_ET_HI) ? ST_NO_SNI : ST_TRUNC, '0, '0);
            walk_reset();
        end else if (bpos != '1) begin
            bpos++;
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        rec_bytes.push_back(b);
    endtask

    task automatic put_word(input logic [15:0] w);
        rec_bytes.push_back(w[15:8]);
        rec_bytes.push_back(w[7:0]);
    endtask

    task automatic put_rand(input int n);
        repeat (n) rec_bytes.push_back(8'($urandom));
    endtask

    task automatic hello_head(input int sid_len, input int cs_len);
        rec_bytes = {};
        put_rand(int'(HEADER_BYTES));
        put_byte(CLIENT_HELLO);
        put_rand(int'(FIXED_PART_SKIP));
        put_byte(8'(sid_len));
        put_rand(sid_len);
        put_word(16'(cs_len));
        put_rand(cs_len);
        put_byte(8'h01);
        put_byte(8'h00);
        put_rand(2);
    endtask

    task automatic other_ext(input logic [15:0] etype, input int len);
        put_word(etype);
        put_word(16'(len));
        put_rand(len);
    endtask

    task automatic sni_ext(input logic [7:0] ntype, input int host_len);
        put_word({EXT_SERVER_NAME, EXT_SERVER_NAME});
        put_word(16'(host_len + 5));
        put_word(16'(host_len + 3));
        put_byte(ntype);
        put_word(16'(host_len));
        put_rand(host_len);
    endtask

    // keep <= 0 or beyond the record ships the whole record, otherwise cut it to keep bytes
    task automatic ship(input int keep);
        t_rec_byte nb;
        int n;
        n = (keep <= 0 || keep > rec_bytes.size()) ? rec_bytes.size() : keep;
        for (int i = 0; i < n; i++) begin
            nb.data  = rec_bytes[i];
            nb.lastb = (i == n - 1);
            bytes_to_send.push_back(nb);
        end
        bytes_shipped += n;
        recs_shipped++;
    endtask

    task automatic random_record();
        int kind;
        int cut;
        kind = $urandom_range(99);
        cut  = 0;
        rec_bytes = {};
        if (kind < 70) begin
            hello_head(($urandom_range(99) < 5) ? 255 : $urandom_range(32),
                       $urandom_range(10) * 2);
            repeat ($urandom_range(3))
                other_ext({8'($urandom), 8'($urandom_range(1, 255))}, $urandom_range(12));
            if ($urandom_range(99) < 80)
                sni_ext(($urandom_range(99) < 90) ? NAME_TYPE_HOST : 8'($urandom_range(1, 255)),
                        ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 24));
            if ($urandom_range(99) < 30) put_rand($urandom_range(1, 8));
            if ($urandom_range(99) < 15) cut = $urandom_range(1, rec_bytes.size());
        end else if (kind < 85) begin
            put_rand(int'(HEADER_BYTES));
            put_byte(8'($urandom));
            put_rand($urandom_range(10));
        end else begin
            put_rand($urandom_range(1, 60));
        end
        ship(cut);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            predict_byte(byte_ch.data_byte, byte_ch.last_byte);
            bytes_accepted++;
            byte_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : byte_driver
        t_rec_byte nb;
        if (!byte_ch.valid || byte_taken) begin
            byte_taken = 1'b0;
            if (i_rst_n && bytes_to_send.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                nb = bytes_to_send.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= nb.data;
                byte_ch.last_byte <= nb.lastb;
            end else begin
                byte_ch.valid     <= 1'b0;
                byte_ch.data_byte <= 8'($urandom);
                byte_ch.last_byte <= 1'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin
        result_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_sni_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (results_due.size() == 0) begin
                report_error($sformatf("result status %0d with none due", result_ch.status));
            end else begin
                want = results_due.pop_front();
                if (result_ch.status !== want.status)
                    report_error($sformatf("status got %0d expected %0d",
                                           result_ch.status, want.status));
                if (result_ch.name_offset !== want.name_offset)
                    report_error($sformatf("name_offset got %0d expected %0d",
                                           result_ch.name_offset, want.name_offset));
                if (result_ch.name_length !== want.name_length)
                    report_error($sformatf("name_length got %0d expected %0d",
                                           result_ch.name_length, want.name_length));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("stalled for %0d cycles with %0d bytes queued, %0d results due",
                         quiet_cycles, bytes_to_send.size(), results_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int mode_bytes0;
        int mode_recs0;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'd0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        err_count         = 0;
        bytes_shipped     = 0;
        recs_shipped      = 0;
        bytes_accepted    = 0;
        quiet_cycles      = 0;
        byte_taken        = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;
        walk_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 86 : 0;
            recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 15 : 0;
            if (mode == 0) begin
                rec_bytes = {}; put_rand(1); ship(0);
                rec_bytes = {}; put_rand(3); ship(0);
                rec_bytes = {}; put_rand(int'(HEADER_BYTES)); ship(0);
                rec_bytes = {}; put_rand(int'(HEADER_BYTES)); put_byte(8'hFF); put_rand(6);
                ship(0);
                rec_bytes = {}; put_rand(int'(HEADER_BYTES)); put_byte(8'h00); ship(0);
                hello_head(0, 2); sni_ext(NAME_TYPE_HOST, 3); ship(0);
                hello_head(32, 4); sni_ext(NAME_TYPE_HOST, 0); ship(0);
                hello_head(1, 2); sni_ext(8'hFF, 4); ship(0);
                hello_head(0, 2); other_ext(16'h0017, 0); ship(0);
                hello_head(0, 0); ship(0);
                hello_head(0, 2); other_ext(16'hFF00, 6); sni_ext(NAME_TYPE_HOST, 5);
                put_rand(7); ship(0);
                hello_head(255, 2); sni_ext(NAME_TYPE_HOST, 8); ship(rec_bytes.size() - 3);
                hello_head(3, 2); other_ext(16'h0010, 20); ship(rec_bytes.size() - 10);
                hello_head(0, 2); put_byte(8'h00); ship(0);
                hello_head(0, 2); sni_ext(NAME_TYPE_HOST, 1); ship(0);
                hello_head(0, 2); sni_ext(NAME_TYPE_HOST, 300); ship(0);
                hello_head(2, 2); sni_ext(NAME_TYPE_HOST, 6); ship(rec_bytes.size() - 7);
            end
            mode_bytes0 = bytes_shipped;
            mode_recs0  = recs_shipped;
            while (bytes_shipped - mode_bytes0 < 160 || recs_shipped - mode_recs0 < 2)
                random_record();
            while (bytes_to_send.size() != 0) @(posedge i_clk);
        end

        while (byte_ch.valid || results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d records, %0d bytes, three pacing modes on both channels",
                 recs_shipped, bytes_accepted);
        $display("results: found %0d, not hello %0d, truncated %0d, no name %0d, bad type %0d",
                 status_seen[ST_FOUND], status_seen[ST_NOT_HELLO], status_seen[ST_TRUNC],
                 status_seen[ST_NO_SNI], status_seen[ST_BAD_TYPE]);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
